@@ rtl/sdspi_pkg.sv @@
// shared types and constants for the sd spi-mode command and block read engine
// no dependencies; imported by sdspi_out_q and sd_spi_command_read_engine_core
package sdspi_pkg;

  // data bytes per block and the width of the byte counter
  localparam int BLOCK_BYTES = 512;
  localparam int BYTE_CNT_W  = 10;

  // register reset and protocol constants
  localparam logic [15:0] R1_TIMEOUT_RESET = 16'd500;
  localparam logic [7:0]  CMD_START        = 8'h40;
  localparam logic [7:0]  START_TOKEN      = 8'hFE;
  localparam logic [7:0]  IDLE_BUS         = 8'hFF;

  // input item modes
  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // read kinds
  localparam logic [1:0] READ_NONE   = 2'd0;
  localparam logic [1:0] READ_SINGLE = 2'd1;
  localparam logic [1:0] READ_MULTI  = 2'd2;
  localparam logic [1:0] READ_BAD    = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_CMD     = 3'd0;
  localparam logic [2:0] KIND_R1      = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;
  localparam logic [2:0] KIND_BUSY    = 3'd5;

  // position of the crc byte inside a six-byte command frame
  localparam logic [2:0] FRAME_LAST = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  read_kind;
    logic [7:0]  card_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  // one result group handed from the engine to the output queue
  typedef struct packed {
    logic       valid;
    logic       frame;        // six-byte command frame, crc built while draining
    logic [39:0] frame_bytes; // first five frame bytes, first byte in the top bits
    out_item_t  single;       // the single result when not a frame
  } load_t;

endpackage

@@ rtl/sdspi_out_q.sv @@
// result queue: holds one result group (a command frame or a single result)
// and drains it one transfer per cycle unless stalled; the frame crc7 is built on the fly
// depends on sdspi_pkg
module sdspi_out_q import sdspi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  load_t     load,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        busy_r;
  logic        frame_r;
  logic [39:0] bytes_r;
  out_item_t   single_r;
  logic [2:0]  ptr_r;
  logic [6:0]  crc_r;
  logic [7:0]  cur_byte;
  logic        xfer;
  logic        group_end;

  // one byte of sd crc7, polynomial x^7 + x^3 + 1
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
    logic [6:0] c;
    logic       fb;
    c = crc_in;
    for (int b = 7; b >= 0; b--) begin
      fb = c[6] ^ data[b];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ 7'h09;
      end
    end
    return c;
  endfunction

  // pick the frame byte under the pointer
  always_comb begin
    case (ptr_r)
      3'd0:    cur_byte = bytes_r[39:32];
      3'd1:    cur_byte = bytes_r[31:24];
      3'd2:    cur_byte = bytes_r[23:16];
      3'd3:    cur_byte = bytes_r[15:8];
      3'd4:    cur_byte = bytes_r[7:0];
      default: cur_byte = {crc_r, 1'b1};
    endcase
  end

  assign out_valid = busy_r;
  assign xfer      = busy_r && !out_stall;
  assign group_end = !frame_r || (ptr_r == FRAME_LAST);
  assign free      = !busy_r || (xfer && group_end);

  // output item
  always_comb begin
    if (frame_r) begin
      out_data.kind  = KIND_CMD;
      out_data.value = cur_byte;
      out_data.last  = (ptr_r == FRAME_LAST);
    end else begin
      out_data = single_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ptr_r  <= 3'd0;
    end else if (load.valid) begin
      busy_r <= 1'b1;
      ptr_r  <= 3'd0;
    end else if (xfer) begin
      if (group_end) begin
        busy_r <= 1'b0;
      end else begin
        ptr_r <= ptr_r + 3'd1;
      end
    end
  end

  // payload and running crc
  always_ff @(posedge clk) begin
    if (load.valid) begin
      frame_r  <= load.frame;
      bytes_r  <= load.frame_bytes;
      single_r <= load.single;
      crc_r    <= 7'd0;
    end else if (xfer && !group_end) begin
      crc_r <= crc7_byte(crc_r, cur_byte);
    end
  end

  // a new group only enters when the old one is gone or leaving
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid |-> free)
    else $error("result group loaded over an undrained group");

  // frame pointer stays within the six bytes
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && frame_r |-> ptr_r <= FRAME_LAST)
    else $error("frame pointer out of range");

  // a frame byte that is held advances only after it was taken
  a_ptr_holds: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_stall && !load.valid |=> $stable(ptr_r) && busy_r)
    else $error("frame pointer moved while stalled");

  // the frame ends with the crc byte, whose stop bit is set
  a_crc_stop_bit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && frame_r && ptr_r == FRAME_LAST |-> out_data.value[0] && out_data.last)
    else $error("command frame end malformed");

endmodule

@@ rtl/sd_spi_command_read_engine_core.sv @@
// sd card spi-mode command and block read engine, top level
// depends on sdspi_pkg and sdspi_out_q
//
//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_stall  in_item_t  (command, card byte, tick)
//  out_*        output     out_valid/out_stall out_item_t (frame byte, r1, data, status)
//  cfg_*        input      cfg_valid/cfg_ready 16-bit r1 timeout in ticks
//
// a card byte or tick item is taken when the queue is free; any result follows next cycle.
// a command yields six frame bytes, one per output transfer (a busy result if a single
// read is pending); input stalls until the sixth is taken; the queue builds crc7 per byte.
// an item with a single result can be taken in the cycle its predecessor's result leaves.
// synchronous active-low reset: idle, no pending read, timeout 500, no clearing pass.
// cfg_ready is always high.

module sd_spi_command_read_engine_core import sdspi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [15:0] cfg_data
);

  // engine phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_R1    = 3'd1;
  localparam logic [2:0] PH_TOKEN = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CRC   = 3'd4;

  localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(BLOCK_BYTES - 1);

  logic [15:0]           timeout_r;
  logic [2:0]            phase_r, phase_nxt;
  logic [15:0]           tick_r, tick_nxt;
  logic [15:0]           tick_inc;
  logic [BYTE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]            pend_r, pend_nxt;
  logic                  q_free;
  logic                  accept;
  load_t                 load;

  assign cfg_ready = 1'b1;
  assign in_stall  = !q_free;
  assign accept    = in_valid && q_free;
  assign tick_inc  = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= R1_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  // per-item engine step
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    load      = '0;
    if (accept) begin
      case (in_data.mode)
        MODE_CMD: begin
          load.valid = 1'b1;
          if (pend_r == READ_SINGLE && phase_r != PH_IDLE) begin
            load.single.kind = KIND_BUSY;
          end else begin
            load.frame       = 1'b1;
            load.frame_bytes = {CMD_START | {2'b00, in_data.cmd_index}, in_data.cmd_arg};
            phase_nxt = PH_R1;
            tick_nxt  = 16'd0;
            cnt_nxt   = '0;
            pend_nxt  = (in_data.read_kind == READ_BAD) ? READ_NONE : in_data.read_kind;
          end
        end
        MODE_BYTE: begin
          case (phase_r)
            PH_R1: begin
              if (!in_data.card_byte[7]) begin
                load.valid        = 1'b1;
                load.single.kind  = KIND_R1;
                load.single.value = in_data.card_byte;
                phase_nxt = (pend_r == READ_NONE) ? PH_IDLE : PH_TOKEN;
              end
            end
            PH_TOKEN: begin
              if (in_data.card_byte == START_TOKEN) begin
                phase_nxt = PH_DATA;
                cnt_nxt   = '0;
              end
            end
            PH_DATA: begin
              load.valid        = 1'b1;
              load.single.kind  = KIND_DATA;
              load.single.value = in_data.card_byte;
              load.single.last  = (cnt_r >= LAST_BYTE);
              if (cnt_r >= LAST_BYTE) begin
                phase_nxt = PH_CRC;
                cnt_nxt   = '0;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            PH_CRC: begin
              // first crc byte is skipped, the second closes the block
              if (cnt_r == '0) begin
                cnt_nxt = BYTE_CNT_W'(1);
              end else begin
                cnt_nxt          = '0;
                load.valid       = 1'b1;
                load.single.kind = KIND_DONE;
                if (pend_r == READ_MULTI) begin
                  phase_nxt = PH_TOKEN;
                end else begin
                  phase_nxt = PH_IDLE;
                  pend_nxt  = READ_NONE;
                end
              end
            end
            default: begin
            end
          endcase
        end
        MODE_TICK: begin
          if (phase_r == PH_R1) begin
            tick_nxt = tick_inc;
            if (tick_inc >= timeout_r) begin
              load.valid        = 1'b1;
              load.single.kind  = KIND_TIMEOUT;
              load.single.value = IDLE_BUS;
              phase_nxt = PH_IDLE;
              pend_nxt  = READ_NONE;
              tick_nxt  = 16'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 16'd0;
      cnt_r   <= '0;
      pend_r  <= READ_NONE;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  sdspi_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .free      (q_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // phase code stays within the defined phases
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_CRC)
    else $error("engine phase out of range");

  // a rejected command leaves the engine state untouched
  a_busy_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid && !load.frame && load.single.kind == KIND_BUSY
    |=> $stable(phase_r) && $stable(pend_r) && $stable(cnt_r))
    else $error("rejected command changed engine state");

  // the crc phase never holds a count beyond one
  a_crc_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CRC |-> cnt_r <= BYTE_CNT_W'(1))
    else $error("crc byte count out of range");

endmodule
